FILE: rtl/shs_pkg.sv
`timescale 1ns / 1ps
// Package for the stepper half-step sequencer: state type, item kinds,
// register indexes, reset values and divider constants. No dependencies.
package shs_pkg;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   // Item kinds
   localparam logic KIND_MOVE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Register indexes
   localparam int unsigned CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEPS_PER_REV = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPEED_RPM     = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PHASE_TABLE   = 2'd2;

   // Register reset values and limits
   localparam logic [15:0] RST_STEPS_PER_REV = 16'd4096;
   localparam logic [15:0] RST_SPEED_RPM     = 16'd12;
   localparam logic [31:0] RST_PHASE_TABLE   = 32'h98C4_6231;
   localparam logic [15:0] MIN_STEPS_PER_REV = 16'd4;

   // Eight-phase half-step cycle, four coils
   localparam int unsigned PHASE_BITS = 3;
   localparam int unsigned COIL_BITS  = 4;

   // Delay arithmetic: milliseconds in a minute, 16-bit serial division
   localparam int unsigned DIV_BITS   = 16;
   localparam int unsigned DIV_CNT_W  = 4;
   localparam logic [DIV_BITS-1:0] MS_PER_MINUTE = 16'd60000;
   localparam int unsigned DELAY_BITS = 14;

endpackage

FILE: rtl/stepper_half_step_sequencer.sv
`timescale 1ns / 1ps
// Stepper half-step sequencer. Tick items and moves that arrive while busy give
// their result in the cycle after acceptance (1 item a cycle while no move is
// being calculated and the output is not stalled). A move that starts runs the
// step-delay calculation through one shared restoring divide step, two
// quotients in turn; the result is loaded from the done state once the output
// is free. Synchronous active-high reset restores the register defaults,
// phase 0, forward, no steps, delay 1 and all coils off. Depends on shs_pkg.
module stepper_half_step_sequencer (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [shs_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [31:0]                           csr_data,
   // command and tick items
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic signed [15:0]                    req_step_count,
   // result items
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [shs_pkg::COIL_BITS-1:0]         rsp_coils,
   output logic                                  rsp_coils_updated,
   output logic                                  rsp_busy_res,
   output logic [shs_pkg::PHASE_BITS-1:0]        rsp_phase_now
);

   // Configuration registers
   logic [15:0] spr_ff;
   logic [15:0] rpm_ff;
   logic [31:0] table_ff;

   // Motion state
   logic [shs_pkg::PHASE_BITS-1:0] phase_ff, phase_in;
   logic                           backward_ff, backward_in;
   logic [15:0]                    steps_ff, steps_in;
   logic [shs_pkg::DELAY_BITS-1:0] wait_ff, wait_in;
   logic [shs_pkg::DELAY_BITS-1:0] delay_ff, delay_in;
   logic [shs_pkg::COIL_BITS-1:0]  coil_ff, coil_in;

   // Sequencer and divider
   shs_pkg::state_type              state_ff, state_in;
   logic [15:0]                     cmd_ff, cmd_in;
   logic [shs_pkg::DIV_BITS-1:0]    quot_ff, quot_in;
   logic [shs_pkg::DIV_BITS-1:0]    rem_ff, rem_in;
   logic [shs_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                            pass_ff, pass_in;

   // Output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [shs_pkg::COIL_BITS-1:0]   rsp_coils_ff, rsp_coils_in;
   logic                            rsp_upd_ff, rsp_upd_in;
   logic                            rsp_busy_ff, rsp_busy_in;
   logic [shs_pkg::PHASE_BITS-1:0]  rsp_phase_ff, rsp_phase_in;

   // Configuration port: always ready, out-of-range values ignored
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         spr_ff   <= shs_pkg::RST_STEPS_PER_REV;
         rpm_ff   <= shs_pkg::RST_SPEED_RPM;
         table_ff <= shs_pkg::RST_PHASE_TABLE;
      end else if (csr_valid) begin
         unique case (csr_index)
            shs_pkg::CSR_STEPS_PER_REV: begin
               if (csr_data[15:0] >= shs_pkg::MIN_STEPS_PER_REV) spr_ff <= csr_data[15:0];
            end
            shs_pkg::CSR_SPEED_RPM: begin
               if (csr_data[15:0] != 16'd0) rpm_ff <= csr_data[15:0];
            end
            shs_pkg::CSR_PHASE_TABLE: begin
               table_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Shared divide step: one restoring iteration
   logic [shs_pkg::DIV_BITS-1:0] divisor;
   logic [shs_pkg::DIV_BITS:0]   div_shift;
   logic                         div_ge;
   logic [shs_pkg::DIV_BITS-1:0] div_rem;
   logic [shs_pkg::DIV_BITS-1:0] div_quot;

   always_comb begin
      divisor   = pass_ff ? rpm_ff : spr_ff;
      div_shift = {rem_ff, quot_ff[shs_pkg::DIV_BITS-1]};
      div_ge    = div_shift >= {1'b0, divisor};
      div_rem   = div_ge ? (shs_pkg::DIV_BITS)'(div_shift - {1'b0, divisor})
                         : div_shift[shs_pkg::DIV_BITS-1:0];
      div_quot  = {quot_ff[shs_pkg::DIV_BITS-2:0], div_ge};
   end

   // Move decode from the held command
   logic        cmd_back;
   logic [15:0] cmd_mag;
   logic [shs_pkg::DELAY_BITS-1:0] new_delay;

   always_comb begin
      cmd_back  = (cmd_ff == 16'd0) || cmd_ff[15];
      cmd_mag   = cmd_ff[15] ? 16'(16'd0 - cmd_ff) : cmd_ff;
      new_delay = (quot_ff == '0) ? shs_pkg::DELAY_BITS'(1)
                                  : quot_ff[shs_pkg::DELAY_BITS-1:0];
   end

   // Next state, stepping and result formation
   logic out_free;
   logic busy_now;
   logic do_step;
   logic load_out;
   logic step_back;
   logic [15:0] step_base;
   logic [shs_pkg::DELAY_BITS-1:0] step_reload;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      pass_in      = pass_ff;
      phase_in     = phase_ff;
      backward_in  = backward_ff;
      steps_in     = steps_ff;
      wait_in      = wait_ff;
      delay_in     = delay_ff;
      coil_in      = coil_ff;
      do_step      = 1'b0;
      load_out     = 1'b0;
      step_back    = backward_ff;
      step_base    = steps_ff;
      step_reload  = delay_ff;

      out_free  = !rsp_valid_ff || rsp_ready;
      busy_now  = (steps_ff != 16'd0) || (wait_ff != '0);
      req_ready = (state_ff == shs_pkg::ST_IDLE) && out_free;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         shs_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               if (req_kind == shs_pkg::KIND_TICK) begin
                  load_out = 1'b1;
                  if (wait_ff != '0) begin
                     wait_in = wait_ff - shs_pkg::DELAY_BITS'(1);
                     if (wait_in == '0 && steps_ff != 16'd0) do_step = 1'b1;
                  end
               end else if (busy_now) begin
                  // move while busy: ignored
                  load_out = 1'b1;
               end else begin
                  cmd_in   = req_step_count;
                  quot_in  = shs_pkg::MS_PER_MINUTE;
                  rem_in   = '0;
                  cnt_in   = '0;
                  pass_in  = 1'b0;
                  state_in = shs_pkg::ST_DIV;
               end
            end
         end
         shs_pkg::ST_DIV: begin
            quot_in = div_quot;
            rem_in  = div_rem;
            cnt_in  = cnt_ff + shs_pkg::DIV_CNT_W'(1);
            if (cnt_ff == '1) begin
               if (!pass_ff) begin
                  // second pass divides the first quotient by the speed
                  pass_in = 1'b1;
                  rem_in  = '0;
               end else begin
                  state_in = shs_pkg::ST_DONE;
               end
            end
         end
         shs_pkg::ST_DONE: begin
            if (out_free) begin
               backward_in = cmd_back;
               delay_in    = new_delay;
               steps_in    = cmd_mag;
               step_back   = cmd_back;
               step_base   = cmd_mag;
               step_reload = new_delay;
               do_step     = cmd_mag != 16'd0;
               load_out    = 1'b1;
               state_in    = shs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = shs_pkg::ST_IDLE;
         end
      endcase

      // One step: latch the pattern, advance the phase, count down the steps, reload the wait
      if (do_step) begin
         coil_in  = table_ff[{phase_ff, 2'b00} +: shs_pkg::COIL_BITS];
         phase_in = step_back ? phase_ff - shs_pkg::PHASE_BITS'(1)
                              : phase_ff + shs_pkg::PHASE_BITS'(1);
         steps_in = step_base - 16'd1;
         wait_in  = step_reload;
      end

      rsp_coils_in = rsp_coils_ff;
      rsp_upd_in   = rsp_upd_ff;
      rsp_busy_in  = rsp_busy_ff;
      rsp_phase_in = rsp_phase_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_coils_in = coil_in;
         rsp_upd_in   = do_step;
         rsp_busy_in  = (steps_in != 16'd0) || (wait_in != '0);
         rsp_phase_in = phase_in;
      end
   end

   // Control and motion registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= shs_pkg::ST_IDLE;
         phase_ff     <= '0;
         backward_ff  <= 1'b0;
         steps_ff     <= '0;
         wait_ff      <= '0;
         delay_ff     <= shs_pkg::DELAY_BITS'(1);
         coil_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         pass_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         backward_ff  <= backward_in;
         steps_ff     <= steps_in;
         wait_ff      <= wait_in;
         delay_ff     <= delay_in;
         coil_ff      <= coil_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         pass_ff      <= pass_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      rsp_coils_ff <= rsp_coils_in;
      rsp_upd_ff   <= rsp_upd_in;
      rsp_busy_ff  <= rsp_busy_in;
      rsp_phase_ff <= rsp_phase_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_coils         = rsp_coils_ff;
   assign rsp_coils_updated = rsp_upd_ff;
   assign rsp_busy_res      = rsp_busy_ff;
   assign rsp_phase_now     = rsp_phase_ff;

endmodule
